// ----- src/lcf_pkg.sv -----
// Shared types and constants for the linear convolution FIR block.
// No dependencies; used by linear_convolution_fir_top.
package lcf_pkg;

  localparam int MAX_TAPS_DEF    = 32;
  localparam int DATA_W          = 16;
  localparam int TAP_COUNT_W     = 6;
  localparam int TAP_INDEX_W     = 5;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int Q_SHIFT         = 15;
  localparam int ROUND_BIAS      = 16384;
  localparam int Q_MAX           = 32767;
  localparam int Q_MIN           = -32768;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(1);

  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PUT
  } state_t;

endpackage

// ----- src/linear_convolution_fir_top.sv -----
// Streaming FIR for full linear convolution of a sample block with a stored kernel.
// Kernel and delay line live in two synchronous memories swept by one MAC.
// Depends on lcf_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------------
//   cfg     | cfg_valid/cfg_ready | cfg_data (tap_count)
//   in      | in_valid/in_ready   | mode, tap_index, coefficient, sample, block_end
//   out     | out_valid/out_ready | value, saturated, last
//
// Each sample word runs through ST_MAC, ST_DRAIN and ST_PUT to its output word; a
// block_end sample adds taps - 1 tail outputs, each again through ST_MAC, ST_DRAIN and
// ST_PUT. The single multiply-accumulate reads one tap per cycle from the kernel and
// delay line memories. rst is synchronous and clears the delay line valid
// bits at once. A stalled output word holds; the next word is accepted meanwhile, and
// the MAC waits only when a new result is ready and the output is still occupied.
module linear_convolution_fir_top #(
  parameter int MAX_TAPS = lcf_pkg::MAX_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcf_pkg::TAP_COUNT_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [lcf_pkg::TAP_INDEX_W-1:0]     tap_index,
  input  logic signed [lcf_pkg::DATA_W-1:0]   coefficient,
  input  logic signed [lcf_pkg::DATA_W-1:0]   sample,
  input  logic                                block_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lcf_pkg::DATA_W-1:0]   value,
  output logic                                saturated,
  output logic                                last
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = lcf_pkg::PROD_W + CW;
  localparam int DW    = lcf_pkg::DATA_W;

  localparam logic [AW-1:0]           LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'(lcf_pkg::Q_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO    = ACC_W'(lcf_pkg::Q_MIN);
  localparam logic signed [ACC_W-1:0] BIAS      = ACC_W'(lcf_pkg::ROUND_BIAS);

  lcf_pkg::state_t state, state_next;

  logic [lcf_pkg::TAP_COUNT_W-1:0] tap_count;
  logic [CW-1:0]                   taps_eff;
  logic [CW-1:0]                   taps;
  logic [CW-1:0]                   tails;
  logic                            blk;
  logic [AW-1:0]                   ptr;
  logic [AW-1:0]                   ptr_dec;
  logic [AW-1:0]                   k;
  logic [AW:0]                     daddr_sum;
  logic [AW-1:0]                   daddr;
  logic [MAX_TAPS-1:0]             dvalid;

  logic signed [DW-1:0]            kmem [MAX_TAPS];
  logic signed [DW-1:0]            dmem [MAX_TAPS];
  logic signed [DW-1:0]            kq;
  logic signed [DW-1:0]            dq;
  logic                            dvq;
  logic                            s1;
  logic                            s2;
  logic signed [lcf_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         rsum;
  logic signed [ACC_W-1:0]         rq;
  logic signed [DW-1:0]            rval;
  logic                            rsat;

  logic in_acc;
  logic smp_acc;
  logic coef_wr;
  logic issue;
  logic last_tap;
  logic out_load;
  logic tail_go;
  logic blk_done;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (tap_count == '0) begin
      taps_eff = CW'(1);
    end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(tap_count);
    end
  end

  assign ptr_dec   = (ptr == '0) ? LAST_ADDR : ptr - AW'(1);
  assign daddr_sum = {1'b0, ptr} + {1'b0, k};
  assign daddr     = (daddr_sum >= (AW+1)'(MAX_TAPS)) ?
                     AW'(daddr_sum - (AW+1)'(MAX_TAPS)) : AW'(daddr_sum);
  assign last_tap  = ({{(CW > AW ? CW - AW : 0){1'b0}}, k} == (taps - CW'(1)));

  // round half up, then clip to Q1.15
  always_comb begin
    rsum = acc + BIAS;
    rq   = rsum >>> lcf_pkg::Q_SHIFT;
    if (rq > SAT_HI) begin
      rval = DW'(lcf_pkg::Q_MAX);
      rsat = 1'b1;
    end else if (rq < SAT_LO) begin
      rval = DW'(lcf_pkg::Q_MIN);
      rsat = 1'b1;
    end else begin
      rval = DW'(rq);
      rsat = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lcf_pkg::ST_IDLE: begin
        if (in_valid && mode == lcf_pkg::MODE_SAMPLE) begin
          state_next = lcf_pkg::ST_MAC;
        end
      end
      lcf_pkg::ST_MAC: begin
        if (last_tap) begin
          state_next = lcf_pkg::ST_DRAIN;
        end
      end
      lcf_pkg::ST_DRAIN: begin
        if (!s1 && !s2) begin
          state_next = lcf_pkg::ST_PUT;
        end
      end
      lcf_pkg::ST_PUT: begin
        if (!out_valid || out_ready) begin
          state_next = (tails != '0) ? lcf_pkg::ST_MAC : lcf_pkg::ST_IDLE;
        end
      end
      default: state_next = lcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == lcf_pkg::ST_IDLE);
    issue    = (state == lcf_pkg::ST_MAC);
    out_load = (state == lcf_pkg::ST_PUT) && (!out_valid || out_ready);
    in_acc   = in_valid && in_ready;
    smp_acc  = in_acc && (mode == lcf_pkg::MODE_SAMPLE);
    coef_wr  = in_acc && (mode == lcf_pkg::MODE_COEF) &&
               (32'(tap_index) < 32'(MAX_TAPS));
    tail_go  = out_load && (tails != '0);
    blk_done = out_load && (tails == '0) && blk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcf_pkg::ST_IDLE;
      tap_count <= lcf_pkg::TAP_COUNT_RESET;
      ptr       <= '0;
      dvalid    <= '0;
      s1        <= 1'b0;
      s2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        tap_count <= cfg_data;
      end
      if (smp_acc) begin
        ptr             <= ptr_dec;
        dvalid[ptr_dec] <= 1'b1;
      end else if (tail_go) begin
        ptr             <= ptr_dec;
        dvalid[ptr_dec] <= 1'b0;
      end else if (blk_done) begin
        dvalid <= '0;
      end
      s1 <= issue;
      s2 <= s1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // kernel memory
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      kmem[AW'(tap_index)] <= coefficient;
    end
    kq <= kmem[k];
  end

  // delay line memory, circular around ptr
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      dmem[ptr_dec] <= sample;
    end
    dq  <= dmem[daddr];
    dvq <= dvalid[daddr];
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      taps  <= taps_eff;
      tails <= block_end ? taps_eff - CW'(1) : '0;
      blk   <= block_end;
    end else if (tail_go) begin
      tails <= tails - CW'(1);
    end
    if (smp_acc || tail_go) begin
      k   <= '0;
      acc <= '0;
    end else begin
      if (issue) begin
        k <= k + AW'(1);
      end
      if (s2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (s1) begin
      prod <= kq * (dvq ? dq : DW'(0));
    end
    if (out_load) begin
      value     <= rval;
      saturated <= rsat;
      last      <= blk && (tails == '0);
    end
  end

  a_idle_drained : assert property (@(posedge clk) disable iff (rst)
    state == lcf_pkg::ST_IDLE |-> !s1 && !s2)
    else $error("MAC pipeline busy while idle");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid || out_ready)
    else $error("output word overwritten");

  a_ptr_range : assert property (@(posedge clk) disable iff (rst)
    32'(ptr) < 32'(MAX_TAPS))
    else $error("delay line pointer out of range");

  a_tail_next : assert property (@(posedge clk) disable iff (rst)
    tail_go |=> state == lcf_pkg::ST_MAC && k == '0)
    else $error("tail output not started");

  a_k_range : assert property (@(posedge clk) disable iff (rst)
    issue |-> 32'(k) < 32'(taps))
    else $error("tap counter past tap count");

endmodule
